FILE: src/drmt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Dirty rectangle merge table package
// Shared constants, opcodes and cell status type.
// ----------------------------------------------------------------------------
package drmt_pkg;

  localparam int unsigned MaxRegionsDef = 16;
  localparam int unsigned CoordBitsDef  = 10;

  localparam int unsigned CfgRegBits  = 11;
  localparam int unsigned CfgIdxBits  = 1;
  localparam int unsigned FieldBits   = 16;

  localparam logic [CfgRegBits-1:0] ScreenWidthRst  = 11'd80;
  localparam logic [CfgRegBits-1:0] ScreenHeightRst = 11'd25;

  localparam logic [CfgIdxBits-1:0] CfgScreenWidth  = 1'b0;
  localparam logic [CfgIdxBits-1:0] CfgScreenHeight = 1'b1;

  // Slot of each coordinate inside a rectangle vector
  localparam int unsigned RectLeft   = 0;
  localparam int unsigned RectTop    = 1;
  localparam int unsigned RectRight  = 2;
  localparam int unsigned RectBottom = 3;

  typedef enum logic {
    OpMark  = 1'b0,
    OpFlush = 1'b1
  } drmt_op_e;

  typedef struct packed {
    logic busy;     // a passing rectangle sits in the cell this cycle
    logic ovf_set;  // forced merge into the final cell
  } drmt_cell_stat_t;

endpackage

`default_nettype wire

FILE: src/drmt_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Dirty rectangle merge table channels
// Request channel (mark / flush) and region response channel.
// ----------------------------------------------------------------------------
interface drmt_req_if;
  logic                                valid;
  logic                                ready;
  logic                                opcode;
  logic signed [drmt_pkg::FieldBits-1:0] rect_x;
  logic signed [drmt_pkg::FieldBits-1:0] rect_y;
  logic signed [drmt_pkg::FieldBits-1:0] rect_w;
  logic signed [drmt_pkg::FieldBits-1:0] rect_h;

  modport source (output valid, opcode, rect_x, rect_y, rect_w, rect_h, input ready);
  modport sink (input valid, opcode, rect_x, rect_y, rect_w, rect_h, output ready);
endinterface

interface drmt_rsp_if #(
  parameter int unsigned CoordBits = drmt_pkg::CoordBitsDef
);
  logic                 valid;
  logic                 ready;
  logic [CoordBits-1:0] region_left;
  logic [CoordBits-1:0] region_top;
  logic [CoordBits-1:0] region_right;
  logic [CoordBits-1:0] region_bottom;
  logic                 overflowed;
  logic                 last_region;

  modport source (
    output valid, region_left, region_top, region_right, region_bottom,
           overflowed, last_region,
    input  ready
  );
  modport sink (
    input  valid, region_left, region_top, region_right, region_bottom,
           overflowed, last_region,
    output ready
  );
endinterface

`default_nettype wire

FILE: src/drmt_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Dirty rectangle merge table cell
// Holds one region; absorbs a passing rectangle or hands it to the next cell.
// ----------------------------------------------------------------------------
module drmt_cell #(
  parameter int unsigned CoordBits = drmt_pkg::CoordBitsDef,
  parameter bit          IsLast    = 1'b0
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      tok_vld_i,
  input  wire logic [3:0][CoordBits-1:0] tok_rect_i,
  input  wire logic                      shift_i,
  input  wire logic                      shift_occ_i,
  input  wire logic [3:0][CoordBits-1:0] shift_rect_i,
  output logic                           occ_o,
  output logic [3:0][CoordBits-1:0]      rect_o,
  output logic                           pass_vld_o,
  output logic [3:0][CoordBits-1:0]      pass_rect_o,
  output drmt_pkg::drmt_cell_stat_t      stat_o
);

  localparam int unsigned L = drmt_pkg::RectLeft;
  localparam int unsigned T = drmt_pkg::RectTop;
  localparam int unsigned R = drmt_pkg::RectRight;
  localparam int unsigned B = drmt_pkg::RectBottom;

  logic                      occ_q, occ_d;
  logic                      tok_vld_q;
  logic [3:0][CoordBits-1:0] rect_q, rect_d;
  logic [3:0][CoordBits-1:0] tok_q, tok_d;
  logic [3:0][CoordBits-1:0] merged;
  logic                      overlap;
  logic                      absorb;

  assign overlap = !(rect_q[R] < tok_q[L] || rect_q[L] > tok_q[R] ||
                     rect_q[B] < tok_q[T] || rect_q[T] > tok_q[B]);

  // The final cell swallows whatever reaches it
  assign absorb = tok_vld_q && (!occ_q || overlap || IsLast);

  always_comb begin
    merged[L] = (tok_q[L] < rect_q[L]) ? tok_q[L] : rect_q[L];
    merged[T] = (tok_q[T] < rect_q[T]) ? tok_q[T] : rect_q[T];
    merged[R] = (tok_q[R] > rect_q[R]) ? tok_q[R] : rect_q[R];
    merged[B] = (tok_q[B] > rect_q[B]) ? tok_q[B] : rect_q[B];
  end

  always_comb begin
    occ_d  = occ_q;
    rect_d = rect_q;
    if (shift_i) begin
      occ_d  = shift_occ_i;
      rect_d = shift_rect_i;
    end else if (absorb) begin
      occ_d  = 1'b1;
      rect_d = occ_q ? merged : tok_q;
    end
  end

  assign tok_d = tok_vld_i ? tok_rect_i : tok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q     <= 1'b0;
      tok_vld_q <= 1'b0;
    end else begin
      occ_q     <= occ_d;
      tok_vld_q <= tok_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rect_q <= rect_d;
    tok_q  <= tok_d;
  end

  assign occ_o          = occ_q;
  assign rect_o         = rect_q;
  assign pass_vld_o     = tok_vld_q && !absorb;
  assign pass_rect_o    = tok_q;
  assign stat_o.busy    = tok_vld_q;
  assign stat_o.ovf_set = IsLast && tok_vld_q && occ_q && !overlap;

endmodule

`default_nettype wire

FILE: src/dirty_rect_merge_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Dirty rectangle merge table
// Clamps marked rectangles to the screen and merges them into a cell chain.
// ----------------------------------------------------------------------------
// A mark request is clamped in its accept cycle and then walks the cell chain
// one cell per cycle until a free or overlapping cell (or the final cell)
// takes it; the request side stays busy while the mark is in the chain, and
// a mark that clamps to nothing never enters it. A flush shifts the chain
// toward the output register one region per cycle while the response side
// takes them, then, once the chain is empty, clears the overflow flag and
// takes requests again. One request is in work at a time; a finished region
// may wait in the output register while the next request is taken.
// ----------------------------------------------------------------------------
module dirty_rect_merge_table #(
  parameter int unsigned MaxRegions = drmt_pkg::MaxRegionsDef,
  parameter int unsigned CoordBits  = drmt_pkg::CoordBitsDef
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [drmt_pkg::CfgIdxBits-1:0]    cfg_idx_i,
  input  wire logic [drmt_pkg::CfgRegBits-1:0]    cfg_wdata_i,
  drmt_req_if.sink                                req_sink,
  drmt_rsp_if.source                              rsp_source
);

  localparam int unsigned L = drmt_pkg::RectLeft;
  localparam int unsigned T = drmt_pkg::RectTop;
  localparam int unsigned R = drmt_pkg::RectRight;
  localparam int unsigned B = drmt_pkg::RectBottom;
  localparam int unsigned CoordLimit = 1 << CoordBits;
  localparam int unsigned SumBits    = drmt_pkg::FieldBits + 2;

  typedef enum logic {
    StRun,
    StFlush
  } state_e;

  state_e                              state_q;
  logic [drmt_pkg::CfgRegBits-1:0]     scr_w_q, scr_h_q;
  logic                                ovf_q;
  logic                                out_vld_q;
  logic [3:0][CoordBits-1:0]           out_rect_q;
  logic                                out_ovf_q;
  logic                                out_last_q;

  // Chain wiring
  logic [MaxRegions-1:0]               occ;
  logic [MaxRegions-1:0]               occ_nx;
  logic [MaxRegions-1:0]               pass_vld;
  logic [MaxRegions-1:0]               busy;
  logic [3:0][CoordBits-1:0]           rect     [MaxRegions];
  logic [3:0][CoordBits-1:0]           rect_nx  [MaxRegions];
  logic [3:0][CoordBits-1:0]           pass_rect[MaxRegions];
  drmt_pkg::drmt_cell_stat_t           stat     [MaxRegions];

  logic                                accept;
  logic                                inject;
  logic                                emit;
  logic [CoordBits-1:0]                wmax, hmax;
  logic signed [SumBits-1:0]           xs, ys, xe, ye;
  logic [3:0][CoordBits-1:0]           clamped;

  function automatic logic [CoordBits-1:0] lim_max(
    input logic [drmt_pkg::CfgRegBits-1:0] sz
  );
    logic [CoordBits-1:0] res;
    if (sz == '0) begin
      res = '0;
    end else if (32'(sz) > CoordLimit) begin
      res = '1;
    end else begin
      res = CoordBits'(32'(sz) - 32'd1);
    end
    return res;
  endfunction

  function automatic logic [CoordBits-1:0] clamp(
    input logic signed [SumBits-1:0] v,
    input logic [CoordBits-1:0]      m
  );
    logic signed [SumBits-1:0] mx;
    logic [CoordBits-1:0]      res;
    mx = signed'(SumBits'(m));
    if (v < 0) begin
      res = '0;
    end else if (v > mx) begin
      res = m;
    end else begin
      res = v[CoordBits-1:0];
    end
    return res;
  endfunction

  // Front end: clamp the incoming rectangle to the screen
  assign wmax = lim_max(scr_w_q);
  assign hmax = lim_max(scr_h_q);
  assign xs   = SumBits'(req_sink.rect_x);
  assign ys   = SumBits'(req_sink.rect_y);
  assign xe   = xs + SumBits'(req_sink.rect_w) - SumBits'(1);
  assign ye   = ys + SumBits'(req_sink.rect_h) - SumBits'(1);

  always_comb begin
    clamped[L] = clamp(xs, wmax);
    clamped[T] = clamp(ys, hmax);
    clamped[R] = clamp(xe, wmax);
    clamped[B] = clamp(ye, hmax);
  end

  assign req_sink.ready = (state_q == StRun) && !(|busy);
  assign accept         = req_sink.valid && req_sink.ready;
  assign inject         = accept && (req_sink.opcode == drmt_pkg::OpMark) &&
                          !(clamped[L] > clamped[R] || clamped[T] > clamped[B]);

  // Drain: move the head region into the output register and shift the chain
  assign emit = (state_q == StFlush) && occ[0] && (!out_vld_q || rsp_source.ready);

  for (genvar i = 0; i < MaxRegions; i++) begin : g_cell
    logic                      tok_vld;
    logic [3:0][CoordBits-1:0] tok_rect;

    if (i == 0) begin : g_head
      assign tok_vld  = inject;
      assign tok_rect = clamped;
    end else begin : g_body
      assign tok_vld  = pass_vld[i-1];
      assign tok_rect = pass_rect[i-1];
    end

    if (i == MaxRegions - 1) begin : g_tail
      assign occ_nx[i]  = 1'b0;
      assign rect_nx[i] = '0;
    end else begin : g_mid
      assign occ_nx[i]  = occ[i+1];
      assign rect_nx[i] = rect[i+1];
    end

    drmt_cell #(
      .CoordBits(CoordBits),
      .IsLast   (i == MaxRegions - 1)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .tok_vld_i   (tok_vld),
      .tok_rect_i  (tok_rect),
      .shift_i     (emit),
      .shift_occ_i (occ_nx[i]),
      .shift_rect_i(rect_nx[i]),
      .occ_o       (occ[i]),
      .rect_o      (rect[i]),
      .pass_vld_o  (pass_vld[i]),
      .pass_rect_o (pass_rect[i]),
      .stat_o      (stat[i])
    );

    assign busy[i] = stat[i].busy;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StRun;
      scr_w_q    <= drmt_pkg::ScreenWidthRst;
      scr_h_q    <= drmt_pkg::ScreenHeightRst;
      ovf_q      <= 1'b0;
      out_vld_q  <= 1'b0;
      out_rect_q <= '0;
      out_ovf_q  <= 1'b0;
      out_last_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          drmt_pkg::CfgScreenWidth:  scr_w_q <= cfg_wdata_i;
          drmt_pkg::CfgScreenHeight: scr_h_q <= cfg_wdata_i;
          default: ;
        endcase
      end

      if (stat[MaxRegions-1].ovf_set) begin
        ovf_q <= 1'b1;
      end

      if (emit) begin
        out_vld_q  <= 1'b1;
        out_rect_q <= rect[0];
        out_ovf_q  <= ovf_q;
        out_last_q <= !occ_nx[0];
      end else if (rsp_source.ready) begin
        out_vld_q <= 1'b0;
      end

      case (state_q)
        StRun: begin
          if (accept && req_sink.opcode == drmt_pkg::OpFlush) begin
            state_q <= StFlush;
          end
        end
        StFlush: begin
          // Table drained: drop the overflow flag and take requests again
          if (!occ[0]) begin
            ovf_q   <= 1'b0;
            state_q <= StRun;
          end
        end
        default: state_q <= StRun;
      endcase
    end
  end

  assign rsp_source.valid         = out_vld_q;
  assign rsp_source.region_left   = out_rect_q[L];
  assign rsp_source.region_top    = out_rect_q[T];
  assign rsp_source.region_right  = out_rect_q[R];
  assign rsp_source.region_bottom = out_rect_q[B];
  assign rsp_source.overflowed    = out_ovf_q;
  assign rsp_source.last_region   = out_last_q;

endmodule

`default_nettype wire

FILE: src/drmt_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Dirty rectangle merge table checker
// Port-level properties of the request and region channels.
// ----------------------------------------------------------------------------
module drmt_checker #(
  parameter int unsigned CoordBits = drmt_pkg::CoordBitsDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  input  wire logic                 in_ready_i,
  input  wire logic                 in_opcode_i,
  input  wire logic                 out_valid_i,
  input  wire logic                 out_ready_i,
  input  wire logic [CoordBits-1:0] out_left_i,
  input  wire logic [CoordBits-1:0] out_top_i,
  input  wire logic [CoordBits-1:0] out_right_i,
  input  wire logic [CoordBits-1:0] out_bottom_i,
  input  wire logic                 out_ovf_i,
  input  wire logic                 out_last_i
);

  // A flush request blocks the request side until the table is drained
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_opcode_i == drmt_pkg::OpFlush |=> !in_ready_i)
    else $error("request taken right after a flush request");

  // Regions only come out of a flush, which holds off new requests
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("region emitted while requests were open");

  // More regions pending: the flush must still be running
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !out_last_i |-> !in_ready_i)
    else $error("flush ended before its last region");

  // Stalled region holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_left_i) &&
      $stable(out_top_i) && $stable(out_right_i) && $stable(out_bottom_i) &&
      $stable(out_ovf_i) && $stable(out_last_i))
    else $error("stalled region changed");

endmodule

bind dirty_rect_merge_table drmt_checker #(
  .CoordBits(CoordBits)
) u_drmt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (req_sink.valid),
  .in_ready_i  (req_sink.ready),
  .in_opcode_i (req_sink.opcode),
  .out_valid_i (rsp_source.valid),
  .out_ready_i (rsp_source.ready),
  .out_left_i  (rsp_source.region_left),
  .out_top_i   (rsp_source.region_top),
  .out_right_i (rsp_source.region_right),
  .out_bottom_i(rsp_source.region_bottom),
  .out_ovf_i   (rsp_source.overflowed),
  .out_last_i  (rsp_source.last_region)
);

`default_nettype wire
